>>> rtl/core/wbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WS2812 bit encoder package
// Shared widths, register codes, reset values and item types for the
// one-wire pulse-width encoder.
// ----------------------------------------------------------------------------
package wbe_pkg;

	// Field and counter widths.
	localparam int unsigned TICK_W    = 10;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned BITS_W    = 4;
	localparam int unsigned CFG_IDX_W = 3;

	// Number of bits sent for one byte.
	localparam logic [BITS_W-1:0] BYTE_BITS = 4'd8;

	// Default depth of the command queue between front and back.
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd3;

	// Reset values of the timing registers.
	localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 10'd10;
	localparam logic [TICK_W-1:0] ZERO_LOW_RST  = 10'd56;
	localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 10'd36;
	localparam logic [TICK_W-1:0] ONE_LOW_RST   = 10'd44;

	// Command kinds after classification in the front.
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	// One input item: one clock tick of the bit timer.
	typedef struct packed {
		logic              func;
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} item_t;

	// One result item.
	typedef struct packed {
		logic pin_level;
		logic busy_res;
		logic byte_done;
		logic frame_done;
		logic load_refused;
	} result_t;

	// Classified command as held in the queue.
	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} cmd_t;

	// Transfer from the front into the queue.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} push_t;

	// A programmed length of zero counts as one tick.
	function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
		at_least_one = (v == '0) ? TICK_W'(1) : v;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/wbe_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WS2812 encoder front
// Accepts tick items, classifies each as a plain tick or a byte load and
// holds it in one register stage until the queue takes it.
// ----------------------------------------------------------------------------
module wbe_front
	import wbe_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   item_valid,
	output logic  item_stall,
	input  item_t item,
	input  wire   queue_full,
	output push_t push
);

	logic valid_s1;
	cmd_t cmd_s1;
	logic take;

	// The stage can load whenever it is empty or its content moves on.
	assign take       = !valid_s1 || !queue_full;
	assign item_stall = !take;

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= item_valid;
		end
	end

	// Classified command payload.
	always_ff @(posedge clk) begin
		if (take && item_valid) begin
			cmd_s1.kind      <= item.func ? CMD_LOAD : CMD_TICK;
			cmd_s1.data_byte <= item.data_byte;
			cmd_s1.last_byte <= item.last_byte;
		end
	end

	assign push.valid = valid_s1;
	assign push.cmd   = cmd_s1;

endmodule
`default_nettype wire

>>> rtl/core/wbe_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WS2812 encoder command queue
// Short first-in first-out buffer that decouples the front from the
// serialiser in the back.
// ----------------------------------------------------------------------------
module wbe_queue
	import wbe_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire   clk,
	input  wire   arst_n,
	input  push_t push,
	output logic  full,
	output logic  head_valid,
	output cmd_t  head,
	input  wire   pop
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head_valid;

	// Storage write.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/wbe_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WS2812 encoder back
// Holds the timing registers and the serialiser state, carries out one
// tick per command and presents the result in an output register.
// ----------------------------------------------------------------------------
module wbe_back
	import wbe_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  head_valid,
	input  cmd_t                 head,
	output logic                 pop,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [TICK_W-1:0]    cfg_data,
	output logic                 result_valid,
	input  wire                  result_stall,
	output result_t              result
);

	logic [TICK_W-1:0] zero_high_q;
	logic [TICK_W-1:0] zero_low_q;
	logic [TICK_W-1:0] one_high_q;
	logic [TICK_W-1:0] one_low_q;

	logic [BYTE_W-1:0] shift_q;
	logic [BITS_W-1:0] bits_left_q;
	logic              high_q;
	logic [TICK_W-1:0] ticks_q;
	logic              frame_pend_q;

	logic              out_valid_q;
	result_t           out_q;

	logic              idle;
	logic              offer;
	logic              load;
	logic              active;
	logic [BYTE_W-1:0] cur_byte;
	logic [BITS_W-1:0] cur_bits;
	logic              cur_high;
	logic [TICK_W-1:0] cur_ticks;
	logic              cur_frame;
	logic [TICK_W-1:0] dur;
	logic [TICK_W-1:0] ticks_next;
	logic              phase_end;
	logic [BITS_W-1:0] bits_dec;
	logic              byte_end;
	result_t           res;

	assign cfg_ready = 1'b1;

	// Timing registers; writes beyond the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_high_q <= ZERO_HIGH_RST;
			zero_low_q  <= ZERO_LOW_RST;
			one_high_q  <= ONE_HIGH_RST;
			one_low_q   <= ONE_LOW_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_ZERO_HIGH) zero_high_q <= cfg_data;
			if (cfg_index == CFG_ZERO_LOW)  zero_low_q  <= cfg_data;
			if (cfg_index == CFG_ONE_HIGH)  one_high_q  <= cfg_data;
			if (cfg_index == CFG_ONE_LOW)   one_low_q   <= cfg_data;
		end
	end

	// A command is taken when the output register is free or being emptied.
	assign pop = head_valid && (!out_valid_q || !result_stall);

	// Load decision: a byte is accepted only while nothing is in progress.
	assign idle   = (bits_left_q == '0);
	assign offer  = (head.kind == CMD_LOAD);
	assign load   = idle && offer;
	assign active = !idle || offer;

	// Effective state for this tick, with a fresh byte taking effect at once.
	assign cur_byte  = load ? head.data_byte : shift_q;
	assign cur_bits  = load ? BYTE_BITS : bits_left_q;
	assign cur_high  = load ? 1'b1 : high_q;
	assign cur_ticks = load ? '0 : ticks_q;
	assign cur_frame = load ? head.last_byte : frame_pend_q;

	// Phase length and end-of-phase test.
	always_comb begin
		if (cur_high) begin
			dur = at_least_one(cur_byte[BYTE_W-1] ? one_high_q : zero_high_q);
		end else begin
			dur = at_least_one(cur_byte[BYTE_W-1] ? one_low_q : zero_low_q);
		end
	end

	assign ticks_next = cur_ticks + 1'b1;
	assign phase_end  = (ticks_next >= dur);
	assign bits_dec   = cur_bits - 1'b1;
	assign byte_end   = active && phase_end && !cur_high && (bits_dec == '0);

	// Result of this tick.
	always_comb begin
		res.pin_level    = active && cur_high;
		res.busy_res     = active;
		res.byte_done    = byte_end;
		res.frame_done   = byte_end && cur_frame;
		res.load_refused = !idle && offer;
	end

	// Serialiser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q      <= '0;
			bits_left_q  <= '0;
			high_q       <= 1'b0;
			ticks_q      <= '0;
			frame_pend_q <= 1'b0;
		end else if (pop && active) begin
			shift_q      <= cur_byte;
			bits_left_q  <= cur_bits;
			high_q       <= cur_high;
			ticks_q      <= ticks_next;
			frame_pend_q <= cur_frame;
			if (phase_end) begin
				ticks_q <= '0;
				if (cur_high) begin
					high_q <= 1'b0;
				end else begin
					high_q      <= !byte_end;
					shift_q     <= {cur_byte[BYTE_W-2:0], 1'b0};
					bits_left_q <= bits_dec;
					if (byte_end) begin
						frame_pend_q <= 1'b0;
					end
				end
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !result_stall) begin
			out_valid_q <= pop;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
`default_nettype wire

>>> rtl/core/ws2812_bit_encoder.sv
// WS2812 one-wire bit encoder. Every transfer on the item channel is one tick
// of the bit timer and produces exactly one transfer on the result channel,
// in order. A tick that offers a byte while the encoder is idle starts that
// byte at once (its first high tick is the same tick); a byte offered while
// another is in progress is dropped and flagged as refused. Each bit is a
// high phase and a low phase whose lengths come from the four timing
// registers, a programmed zero counting as one tick. The block takes one
// item per clock cycle, sustained, as long as results are taken; the figure
// is set by the serialiser in the back, which updates its state once per
// tick. Each item passes through the front register, the command queue and
// the output register before its result appears. The queue lets the input
// side keep transferring while the result side stalls, until it is full.
// Timing registers are written through the configuration channel, which is
// always ready; write them only while no tick is in flight.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WS2812 bit encoder top level
// Front register, command queue and serialiser back end.
// ----------------------------------------------------------------------------
module ws2812_bit_encoder
	import wbe_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 result_valid,
	input  wire                  result_stall,
	output result_t              result,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [TICK_W-1:0]    cfg_data
);

	push_t push;
	logic  queue_full;
	logic  head_valid;
	cmd_t  head;
	logic  pop;

	// Accept and classify.
	wbe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.queue_full (queue_full),
		.push       (push)
	);

	// Decoupling queue.
	wbe_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// Serialise and report.
	wbe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

>>> rtl/core/wbe_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WS2812 encoder port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module wbe_checker
	import wbe_pkg::*;
(
	input wire     clk,
	input wire     arst_n,
	input wire     result_valid,
	input wire     result_stall,
	input result_t result
);

	// A stalled result stays offered.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result does not change.
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result changed while stalled");

	// The pin is only driven high while a byte is in progress.
	a_pin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.pin_level |-> result.busy_res)
		else $error("pin high while idle");

	// The end of a byte falls on a low tick of a busy period.
	a_byte_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.byte_done |-> result.busy_res && !result.pin_level)
		else $error("byte end outside a low tick");

	// A frame only ends together with its last byte.
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.frame_done |-> result.byte_done)
		else $error("frame end without byte end");

endmodule

bind ws2812_bit_encoder wbe_checker u_wbe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
`default_nettype wire
